### rtl/emt_pkg.sv
// shared constants and types for the exact-match key table
`default_nettype none

package emt_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 64;
  localparam int KEY_W = 64;
  localparam int VAL_W = 16;

  typedef enum logic [1:0] {
    WS_NONE    = 2'd0,
    WS_STORED  = 2'd1,
    WS_DROPPED = 2'd2
  } wstat_t;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0] val_t;

endpackage

`default_nettype wire

### rtl/emt_if.sv
// request and response channel interfaces of the exact-match key table
`default_nettype none

interface emt_req_if;
  import emt_pkg::*;

  logic  valid;
  logic  ready;
  logic  action;
  key_t  lookup_key;
  val_t  entry_value;

  modport source (output valid, output action, output lookup_key, output entry_value,
                  input ready);
  modport sink (input valid, input action, input lookup_key, input entry_value,
                output ready);
endinterface

interface emt_rsp_if;
  import emt_pkg::*;

  logic   valid;
  logic   ready;
  val_t   result_value;
  logic   hit;
  wstat_t write_status;

  modport source (output valid, output result_value, output hit, output write_status,
                  input ready);
  modport sink (input valid, input result_value, input hit, input write_status,
                output ready);
endinterface

`default_nettype wire

### rtl/emt_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module emt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/exact_match_table_mac_key_core.sv
// exact-match table core: 64-bit key to 16-bit value, lookup and insert/replace
//
// usage
//   req channel carries one item: action (0 lookup, 1 write), lookup_key and
//   entry_value. rsp channel returns one item per request: result_value and hit
//   for a lookup, write_status (stored or dropped when full) for a write.
//   keys and values sit together in one ram entry; slots fill from index 0
//   upward and are never freed, so a fill count marks the valid slots.
//   each item scans the filled slots one ram read per cycle, stopping at the
//   first match; the ram read is registered, so each compare uses the data
//   of the read issued before it. a miss scans all filled slots and a hit
//   stops at its slot; the emit state then hands the result to the output
//   register and the core goes back to idle. one item is worked on at a
//   time; req.ready is high in idle.
//   rsp holds its item in an output register; while rsp.ready is low that item
//   waits, the next item may still be taken and scanned, but its result then
//   waits in the emit state and no further item is taken.
//   reset (synchronous, active high) empties the table at once by clearing
//   the fill count; no clearing pass is needed.
`default_nettype none

module exact_match_table_mac_key_core #(
  parameter int TABLE_DEPTH = emt_pkg::TABLE_DEPTH_DEFAULT
) (
  input wire logic clk,
  input wire logic rst,
  emt_req_if.sink  req,
  emt_rsp_if.source rsp
);
  import emt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = KEY_W + VAL_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state, state_next;

  // request held for the whole scan
  logic   req_act;
  key_t   req_key;
  val_t   req_val;

  // fill count: slots below it are valid
  logic [CW-1:0] fill, fill_next;
  // next slot to read, and the tag of the read in flight
  logic [CW-1:0] scan_ptr, scan_ptr_next;
  logic          rd_vld, rd_vld_next;
  logic [AW-1:0] rd_tag;

  // finished result waiting for the output register
  val_t   pend_value, pend_value_next;
  logic   pend_hit, pend_hit_next;
  wstat_t pend_status, pend_status_next;

  // output register
  logic   out_vld;
  val_t   out_value;
  logic   out_hit;
  wstat_t out_status;

  // ram ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  key_t rd_key;
  val_t rd_value;
  logic key_match;
  logic out_free;

  emt_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_ptr[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_key    = ram_rdata[EW-1:VAL_W];
  assign rd_value  = ram_rdata[VAL_W-1:0];
  assign key_match = rd_vld && (rd_key == req_key);
  assign ram_wdata = {req_key, req_val};
  assign out_free  = !out_vld || rsp.ready;

  always_comb begin
    state_next       = state;
    fill_next        = fill;
    scan_ptr_next    = scan_ptr;
    rd_vld_next      = 1'b0;
    ram_re           = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = rd_tag;
    pend_value_next  = pend_value;
    pend_hit_next    = pend_hit;
    pend_status_next = pend_status;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next    = S_SCAN;
          scan_ptr_next = '0;
        end
      end
      S_SCAN: begin
        if (key_match) begin
          // key present at slot rd_tag
          state_next = S_EMIT;
          if (!req_act) begin
            pend_value_next  = rd_value;
            pend_hit_next    = 1'b1;
            pend_status_next = WS_NONE;
          end else begin
            ram_we           = 1'b1;
            ram_waddr        = rd_tag;
            pend_value_next  = '0;
            pend_hit_next    = 1'b0;
            pend_status_next = WS_STORED;
          end
        end else if (!rd_vld && (scan_ptr == fill)) begin
          // all filled slots seen, no match
          state_next      = S_EMIT;
          pend_value_next = '0;
          pend_hit_next   = 1'b0;
          if (!req_act) begin
            pend_status_next = WS_NONE;
          end else if (fill < CW'(TABLE_DEPTH)) begin
            ram_we           = 1'b1;
            ram_waddr        = fill[AW-1:0];
            fill_next        = fill + 1'b1;
            pend_status_next = WS_STORED;
          end else begin
            pend_status_next = WS_DROPPED;
          end
        end else if (scan_ptr < fill) begin
          ram_re        = 1'b1;
          scan_ptr_next = scan_ptr + 1'b1;
          rd_vld_next   = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      scan_ptr <= '0;
      rd_vld   <= 1'b0;
      out_vld  <= 1'b0;
    end else begin
      state    <= state_next;
      fill     <= fill_next;
      scan_ptr <= scan_ptr_next;
      rd_vld   <= rd_vld_next;
      if (state == S_EMIT && out_free) begin
        out_vld <= 1'b1;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_act <= req.action;
      req_key <= req.lookup_key;
      req_val <= req.entry_value;
    end
    if (ram_re) begin
      rd_tag <= scan_ptr[AW-1:0];
    end
    pend_value  <= pend_value_next;
    pend_hit    <= pend_hit_next;
    pend_status <= pend_status_next;
    if (state == S_EMIT && out_free) begin
      out_value  <= pend_value;
      out_hit    <= pend_hit;
      out_status <= pend_status;
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_vld;
  assign rsp.result_value = out_value;
  assign rsp.hit          = out_hit;
  assign rsp.write_status = out_status;

  // fill count never passes the table size
  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // the scan never reads past the filled slots
  a_scan_bound : assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_ptr <= fill))
    else $error("scan pointer beyond fill count");

  // an accepted item starts a scan on the next cycle
  a_accept_scan : assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_SCAN))
    else $error("accepted item did not start a scan");

  // the table grows only by a write item that found no free-slot problem
  a_fill_grow : assert property (@(posedge clk) disable iff (rst)
    (fill != $past(fill)) |-> ($past(state) == S_SCAN && $past(req_act)
      && fill == $past(fill) + 1'b1))
    else $error("fill count changed outside a write");

endmodule

`default_nettype wire

### tb/exact_match_table_mac_key_core_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the exact-match key table core
module exact_match_table_mac_key_core_tb;
  import emt_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEFAULT;

  // request action codes
  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_WRITE  = 1'b1;

  // random items per idling phase, four phases
  localparam int PHASE_ITEMS = 110;
  // worst item is a full scan of the table; the drain is sized from the depth
  localparam int DRAIN_CYCLES = 3 * DEPTH + 20;
  // ~470 items; the limit is set many times over what they need
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    val_t   value;
    logic   hit;
    wstat_t status;
  } table_reply_t;

  logic clk;
  logic rst;

  emt_req_if req_ch();
  emt_rsp_if rsp_ch();

  exact_match_table_mac_key_core #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  // shadow copy of the table, updated as each request item is accepted
  key_t shadow_key   [DEPTH];
  val_t shadow_val   [DEPTH];
  logic shadow_valid [DEPTH];

  // replies predicted but not yet seen on the response channel
  table_reply_t pending_replies[$];
  table_reply_t oldest_reply;
  // keys that have been written (or tried), reused to get hits and replaces
  key_t known_keys[$];

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int error_count = 0;
  int items_sent = 0;
  int replies_seen = 0;
  int lookup_hits = 0;
  int lookup_misses = 0;
  int writes_stored = 0;
  int writes_dropped = 0;
  int cycle_count = 0;

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // predict the reply to one accepted item and apply it to the shadow table;
  // matching takes the lowest valid slot, a new key takes the lowest free one
  function automatic table_reply_t predict_reply(logic act, key_t key, val_t val);
    table_reply_t r;
    int idx;
    r.value = '0;
    r.hit = 1'b0;
    r.status = WS_NONE;
    idx = -1;
    for (int i = DEPTH - 1; i >= 0; i--)
      if (shadow_valid[i] && shadow_key[i] == key) idx = i;
    if (act == ACT_LOOKUP) begin
      if (idx >= 0) begin
        r.value = shadow_val[idx];
        r.hit = 1'b1;
        lookup_hits++;
      end else begin
        lookup_misses++;
      end
      return r;
    end
    if (idx < 0)
      for (int i = DEPTH - 1; i >= 0; i--)
        if (!shadow_valid[i]) idx = i;
    if (idx < 0) begin
      // table full and key absent: nothing changes
      r.status = WS_DROPPED;
      writes_dropped++;
    end else begin
      shadow_key[idx] = key;
      shadow_val[idx] = val;
      shadow_valid[idx] = 1'b1;
      r.status = WS_STORED;
      writes_stored++;
    end
    return r;
  endfunction

  function automatic bit table_full();
    bit full;
    full = 1'b1;
    for (int i = 0; i < DEPTH; i++)
      if (!shadow_valid[i]) full = 1'b0;
    return full;
  endfunction

  // fresh 64-bit key: mostly dense random, sometimes a walking one
  function automatic key_t fresh_key();
    key_t k;
    if ($urandom_range(9) == 0)
      k = key_t'(1) << $urandom_range(KEY_W - 1);
    else
      k = {$urandom, $urandom};
    return k;
  endfunction

  // drive one request item and hold it until the core takes it; valid stays
  // high into the next item unless the sender decides to idle first
  task automatic send_item(input logic act, input key_t key, input val_t val);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= act;
    req_ch.lookup_key <= key;
    req_ch.entry_value <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_replies.push_back(predict_reply(act, key, val));
    items_sent++;
  endtask

  // response side: compare each reply with the oldest prediction, then pick
  // the ready level for the next cycle
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        $display("%0t: reply with none expected: value=%h hit=%b status=%0d",
                 $time, rsp_ch.result_value, rsp_ch.hit, rsp_ch.write_status);
        error_count++;
      end else begin
        oldest_reply = pending_replies.pop_front();
        if (rsp_ch.result_value !== oldest_reply.value) begin
          $display("%0t: result_value expected %h actual %h",
                   $time, oldest_reply.value, rsp_ch.result_value);
          error_count++;
        end
        if (rsp_ch.hit !== oldest_reply.hit) begin
          $display("%0t: hit expected %b actual %b", $time, oldest_reply.hit, rsp_ch.hit);
          error_count++;
        end
        if (rsp_ch.write_status !== oldest_reply.status) begin
          $display("%0t: write_status expected %0d actual %0d",
                   $time, oldest_reply.status, rsp_ch.write_status);
          error_count++;
        end
      end
    end
    rsp_ch.ready <= (snk_stall_pct == 0) || ($urandom_range(99) >= snk_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d replies outstanding", $time, pending_replies.size());
      $display("exact_match_table_mac_key_core: mismatch");
      $finish;
    end
  end

  // lookups on an empty table miss at both key extremes
  task automatic test_empty_lookups();
    send_item(ACT_LOOKUP, '0, '1);
    send_item(ACT_LOOKUP, '1, '0);
  endtask

  // writes of extreme keys and values, read back, with near-miss lookups
  task automatic test_write_then_lookup();
    send_item(ACT_WRITE, '0, 16'hffff);
    send_item(ACT_WRITE, '1, 16'h0000);
    send_item(ACT_WRITE, 64'h8000_0000_0000_0001, 16'h5a5a);
    send_item(ACT_WRITE, 64'h5555_aaaa_3333_cccc, 16'h8001);
    known_keys.push_back('0);
    known_keys.push_back('1);
    known_keys.push_back(64'h8000_0000_0000_0001);
    known_keys.push_back(64'h5555_aaaa_3333_cccc);
    send_item(ACT_LOOKUP, '0, 16'h1234);
    send_item(ACT_LOOKUP, '1, '1);
    send_item(ACT_LOOKUP, 64'h8000_0000_0000_0001, '0);
    send_item(ACT_LOOKUP, 64'h5555_aaaa_3333_cccc, '0);
    // single-bit neighbors of stored keys must miss
    send_item(ACT_LOOKUP, 64'h0000_0000_0000_0001, '0);
    send_item(ACT_LOOKUP, 64'hffff_ffff_ffff_fffe, '0);
    send_item(ACT_LOOKUP, 64'h8000_0000_0000_0000, '0);
  endtask

  // rewriting a present key replaces its value in place
  task automatic test_replace();
    send_item(ACT_WRITE, '0, 16'h1234);
    send_item(ACT_LOOKUP, '0, '0);
    send_item(ACT_WRITE, '1, 16'hffff);
    send_item(ACT_LOOKUP, '1, '0);
  endtask

  // mixed traffic: mostly reuse of known keys so lookups hit and writes
  // replace, plus fresh keys that fill the table and later get dropped
  task automatic test_random_traffic(input int count, input int src_pct, input int snk_pct);
    int r;
    int new_pct;
    key_t key;
    logic act;
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    repeat (count) begin
      new_pct = table_full() ? 20 : 45;
      r = $urandom_range(99);
      act = ($urandom_range(99) < 55) ? ACT_WRITE : ACT_LOOKUP;
      if (r < new_pct || known_keys.size() == 0) begin
        key = fresh_key();
        if (act == ACT_WRITE) known_keys.push_back(key);
      end else begin
        key = known_keys[$urandom_range(known_keys.size() - 1)];
        // near miss: one bit off a known key
        if (r < new_pct + 10) key[$urandom_range(KEY_W - 1)] ^= 1'b1;
      end
      send_item(act, key, val_t'($urandom));
    end
    src_idle_pct = 0;
    snk_stall_pct = 0;
  endtask

  // full-table behavior: a new key is dropped, a present key is replaced
  task automatic test_full_table();
    key_t last_key;
    key_t first_key;
    key_t spare_key;
    while (!table_full()) send_item(ACT_WRITE, fresh_key(), val_t'($urandom));
    last_key = shadow_key[DEPTH - 1];
    first_key = shadow_key[0];
    spare_key = fresh_key();
    send_item(ACT_WRITE, spare_key, 16'hbeef);
    send_item(ACT_LOOKUP, spare_key, '0);
    send_item(ACT_WRITE, last_key, 16'hffff);
    send_item(ACT_LOOKUP, last_key, '0);
    send_item(ACT_WRITE, first_key, 16'h0000);
    send_item(ACT_LOOKUP, first_key, '1);
    send_item(ACT_WRITE, spare_key, 16'h0000);
  endtask

  initial begin
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.action <= ACT_LOOKUP;
    req_ch.lookup_key <= '0;
    req_ch.entry_value <= '0;
    for (int i = 0; i < DEPTH; i++) begin
      shadow_key[i] = '0;
      shadow_val[i] = '0;
      shadow_valid[i] = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_lookups();
    test_write_then_lookup();
    test_replace();

    // idling phases: none, sender only, receiver only, both
    test_random_traffic(PHASE_ITEMS, 0, 0);
    test_random_traffic(PHASE_ITEMS, 47, 0);
    test_random_traffic(PHASE_ITEMS, 0, 47);
    test_random_traffic(PHASE_ITEMS, 38, 38);

    test_full_table();

    // drain, then give any stray reply time to show up
    req_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d items, %0d replies; lookups %0d hit / %0d missed",
             items_sent, replies_seen, lookup_hits, lookup_misses);
    $display("run: writes %0d stored, %0d dropped on a full table of %0d slots",
             writes_stored, writes_dropped, DEPTH);
    if (error_count == 0 && pending_replies.size() == 0) begin
      $display("exact_match_table_mac_key_core: match");
    end else begin
      $display("exact_match_table_mac_key_core: mismatch");
    end
    $finish;
  end

endmodule

### exact_match_table_mac_key_core.f
rtl/emt_pkg.sv
rtl/emt_if.sv
rtl/emt_ram.sv
rtl/exact_match_table_mac_key_core.sv
tb/exact_match_table_mac_key_core_tb.sv
